FILE: design/pll_bringup_supervisor_defines.svh
// Assertion macros used by the checker file of the PLL bring-up supervisor.
// No dependencies; include by bare file name.
`ifndef PLL_BRINGUP_SUPERVISOR_DEFINES_SVH
`define PLL_BRINGUP_SUPERVISOR_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define PBS_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PBS_ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/pbs_pkg.sv
// Shared types and constants of the PLL bring-up supervisor.
// No dependencies; used by every module of the block.
`default_nettype none
package pbs_pkg;

	typedef enum logic [2:0] {
		ST_INIT     = 3'd0,
		ST_RESET    = 3'd1,
		ST_SYSCLK   = 3'd2,
		ST_WAITLOCK = 3'd3,
		ST_SETUP    = 3'd4,
		ST_RUN      = 3'd5,
		ST_ERROR    = 3'd6,
		ST_FATAL    = 3'd7
	} st_t;

	typedef enum logic [1:0] {
		H_UNKNOWN = 2'd0,
		H_NORMAL  = 2'd1,
		H_FAIL    = 2'd2
	} hl_t;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned TO_W   = 16;
	localparam int unsigned RTY_W  = 3;

	localparam logic [2:0] REG_DETECT_TO   = 3'd0;
	localparam logic [2:0] REG_LOCK_TO     = 3'd1;
	localparam logic [2:0] REG_ERR_WAIT    = 3'd2;
	localparam logic [2:0] REG_FATAL_HOLD  = 3'd3;
	localparam logic [2:0] REG_MAX_RETRIES = 3'd4;

	localparam logic [TO_W-1:0]  DETECT_TO_RST   = 16'd2000;
	localparam logic [TO_W-1:0]  LOCK_TO_RST     = 16'd2000;
	localparam logic [TO_W-1:0]  ERR_WAIT_RST    = 16'd1000;
	localparam logic [TO_W-1:0]  FATAL_HOLD_RST  = 16'd2000;
	localparam logic [RTY_W-1:0] MAX_RETRIES_RST = 3'd3;
	localparam logic [RTY_W-1:0] RETRY_SAT       = 3'd7;

	typedef struct packed {
		logic [TO_W-1:0]  detect_timeout;
		logic [TO_W-1:0]  lock_timeout;
		logic [TO_W-1:0]  error_retry_wait;
		logic [TO_W-1:0]  fatal_hold_time;
		logic [RTY_W-1:0] max_retries;
	} cfg_t;

	typedef struct packed {
		logic        enable;
		logic [31:0] now_tick;
		logic        gpio_test_ok;
		logic        soft_reset_ok;
		logic        chip_detected;
		logic        sysclk_setup_ok;
		logic        sysclk_calib_ok;
		logic        main_setup_ok;
		logic        lock_read_ok;
		logic        lock_read_bit;
		logic        irq_poll_ok;
		logic        status_read_ok;
	} item_t;

	typedef struct packed {
		st_t  fsm_code;
		hl_t  device_health;
		logic hold_reset_pin;
		logic release_reset_pin;
		logic pulse_reset_pin;
		logic lock_status;
		logic state_changed;
		logic started_event;
		logic iface_error_event;
	} res_t;

endpackage
`default_nettype wire

FILE: design/pll_bringup_supervisor.sv
// Top level of the PLL bring-up supervisor: input register, step core, result register.
// Depends on pbs_pkg, pbs_cfg and pbs_core.
//
//   channel  handshake                  payload
//   -------  -------------------------  ------------------------------------------
//   input    in_valid / in_ready        enable, now_tick, ten poll result bits
//   output   out_valid / out_ready      fsm_code, device_health, pin and event bits
//   config   psel/penable/pwrite/pready paddr[4:0], pwdata / prdata (32 bit)
//
// One transaction per cycle sustained while out_ready holds; an accepted poll waits in the input
// register, and its step result is then written into the output register.
// The step logic reads the state registers and the registered poll in one pass,
// so the throughput is set by that single state update per cycle.
// arst_n clears the state to init, health unknown, retry count and lock bit zero,
// and loads the register defaults; both pipeline stages come up empty.
// A stalled output holds the result register and, behind it, one queued poll.
`default_nettype none
module pll_bringup_supervisor (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        enable,
	input  wire logic [31:0] now_tick,
	input  wire logic        gpio_test_ok,
	input  wire logic        soft_reset_ok,
	input  wire logic        chip_detected,
	input  wire logic        sysclk_setup_ok,
	input  wire logic        sysclk_calib_ok,
	input  wire logic        main_setup_ok,
	input  wire logic        lock_read_ok,
	input  wire logic        lock_read_bit,
	input  wire logic        irq_poll_ok,
	input  wire logic        status_read_ok,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       fsm_code,
	output logic [1:0]       device_health,
	output logic             hold_reset_pin,
	output logic             release_reset_pin,
	output logic             pulse_reset_pin,
	output logic             lock_status,
	output logic             state_changed,
	output logic             started_event,
	output logic             iface_error_event,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	pbs_pkg::cfg_t  cfg;
	pbs_pkg::item_t item_in;
	pbs_pkg::item_t item_s1;
	logic           valid_s1;
	pbs_pkg::res_t  res_step;
	pbs_pkg::res_t  res_s2;
	logic           valid_s2;
	logic           advance;
	logic           in_take;

	// Register file: the user must write it only while the block is idle; the block does not enforce this.
	pbs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Pack the poll fields into one item.
	assign item_in.enable          = enable;
	assign item_in.now_tick        = now_tick;
	assign item_in.gpio_test_ok    = gpio_test_ok;
	assign item_in.soft_reset_ok   = soft_reset_ok;
	assign item_in.chip_detected   = chip_detected;
	assign item_in.sysclk_setup_ok = sysclk_setup_ok;
	assign item_in.sysclk_calib_ok = sysclk_calib_ok;
	assign item_in.main_setup_ok   = main_setup_ok;
	assign item_in.lock_read_ok    = lock_read_ok;
	assign item_in.lock_read_bit   = lock_read_bit;
	assign item_in.irq_poll_ok     = irq_poll_ok;
	assign item_in.status_read_ok  = status_read_ok;

	// Advance the queued poll whenever the result register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
	end

	// State update happens only when the step result is moved into the result register.
	pbs_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_step;
		end
	end

	assign out_valid         = valid_s2;
	assign fsm_code          = res_s2.fsm_code;
	assign device_health     = res_s2.device_health;
	assign hold_reset_pin    = res_s2.hold_reset_pin;
	assign release_reset_pin = res_s2.release_reset_pin;
	assign pulse_reset_pin   = res_s2.pulse_reset_pin;
	assign lock_status       = res_s2.lock_status;
	assign state_changed     = res_s2.state_changed;
	assign started_event     = res_s2.started_event;
	assign iface_error_event = res_s2.iface_error_event;
endmodule
`default_nettype wire

FILE: design/pbs_cfg.sv
// APB-style configuration register file of the PLL bring-up supervisor.
// Depends on pbs_pkg.
`default_nettype none
module pbs_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pbs_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [pbs_pkg::DATA_W-1:0]   pwdata,
	output logic      [pbs_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output pbs_pkg::cfg_t                     cfg
);
	logic [2:0]   idx;
	logic         wr_en;
	pbs_pkg::cfg_t cfg_q;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_timeout   <= pbs_pkg::DETECT_TO_RST;
			cfg_q.lock_timeout     <= pbs_pkg::LOCK_TO_RST;
			cfg_q.error_retry_wait <= pbs_pkg::ERR_WAIT_RST;
			cfg_q.fatal_hold_time  <= pbs_pkg::FATAL_HOLD_RST;
			cfg_q.max_retries      <= pbs_pkg::MAX_RETRIES_RST;
		end else if (wr_en) begin
			unique case (idx)
				pbs_pkg::REG_DETECT_TO:   cfg_q.detect_timeout   <= pwdata[15:0];
				pbs_pkg::REG_LOCK_TO:     cfg_q.lock_timeout     <= pwdata[15:0];
				pbs_pkg::REG_ERR_WAIT:    cfg_q.error_retry_wait <= pwdata[15:0];
				pbs_pkg::REG_FATAL_HOLD:  cfg_q.fatal_hold_time  <= pwdata[15:0];
				pbs_pkg::REG_MAX_RETRIES: cfg_q.max_retries      <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pbs_pkg::REG_DETECT_TO:   prdata = {16'd0, cfg_q.detect_timeout};
			pbs_pkg::REG_LOCK_TO:     prdata = {16'd0, cfg_q.lock_timeout};
			pbs_pkg::REG_ERR_WAIT:    prdata = {16'd0, cfg_q.error_retry_wait};
			pbs_pkg::REG_FATAL_HOLD:  prdata = {16'd0, cfg_q.fatal_hold_time};
			pbs_pkg::REG_MAX_RETRIES: prdata = {29'd0, cfg_q.max_retries};
			default:                  prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/pbs_core.sv
// Supervisor state registers and the single-step transition logic.
// Depends on pbs_pkg.
`default_nettype none
module pbs_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  pbs_pkg::item_t      item,
	input  pbs_pkg::cfg_t       cfg,
	output pbs_pkg::res_t       res
);
	pbs_pkg::st_t     state_q;
	logic [31:0]      entry_tick_q;
	logic [2:0]       retry_q;
	pbs_pkg::hl_t     health_q;
	logic             lock_q;

	pbs_pkg::st_t     st_a;
	pbs_pkg::st_t     st_n;
	pbs_pkg::hl_t     health_n;
	logic [2:0]       retry_n;
	logic             lock_n;
	logic [31:0]      entry_n;
	logic [31:0]      elapsed;
	logic             in_flow;
	logic             hold;
	logic             release_pin;
	logic             pulse;
	logic             changed;
	logic             started;
	logic             ierr;

	assign elapsed = item.now_tick - entry_tick_q;

	always_comb begin
		st_a        = state_q;
		st_n        = state_q;
		health_n    = health_q;
		retry_n     = retry_q;
		lock_n      = lock_q;
		entry_n     = entry_tick_q;
		in_flow     = 1'b0;
		hold        = 1'b0;
		release_pin = 1'b0;
		pulse       = 1'b0;
		changed     = 1'b0;
		started     = 1'b0;
		ierr        = 1'b0;

		if (!item.enable) begin
			// shutdown: drop to init and assert the chip reset pin
			if (state_q != pbs_pkg::ST_INIT) begin
				st_n     = pbs_pkg::ST_INIT;
				health_n = pbs_pkg::H_UNKNOWN;
				lock_n   = 1'b0;
				hold     = 1'b1;
				changed  = 1'b1;
			end
		end else begin
			unique case (state_q)
				pbs_pkg::ST_INIT: begin
					release_pin = 1'b1;
					st_a = item.gpio_test_ok ? pbs_pkg::ST_RESET : pbs_pkg::ST_ERROR;
				end
				pbs_pkg::ST_RESET: begin
					pulse = 1'b1;
					if (!item.soft_reset_ok) begin
						st_a = pbs_pkg::ST_ERROR;
					end else begin
						health_n = item.chip_detected ? pbs_pkg::H_NORMAL : pbs_pkg::H_FAIL;
						if (item.chip_detected) begin
							st_a = pbs_pkg::ST_SYSCLK;
						end else if (elapsed > {16'd0, cfg.detect_timeout}) begin
							st_a = pbs_pkg::ST_ERROR;
						end
					end
				end
				pbs_pkg::ST_SYSCLK: begin
					st_a = (item.sysclk_setup_ok && item.sysclk_calib_ok) ?
						pbs_pkg::ST_WAITLOCK : pbs_pkg::ST_ERROR;
				end
				pbs_pkg::ST_WAITLOCK: begin
					// timeout wins over a lock seen in the same step
					if (elapsed > {16'd0, cfg.lock_timeout}) begin
						st_a = pbs_pkg::ST_ERROR;
					end else if (lock_q) begin
						st_a = pbs_pkg::ST_SETUP;
					end
				end
				pbs_pkg::ST_SETUP: begin
					st_a = item.main_setup_ok ? pbs_pkg::ST_RUN : pbs_pkg::ST_ERROR;
				end
				pbs_pkg::ST_RUN: begin
					if (!lock_q) begin
						st_a = pbs_pkg::ST_WAITLOCK;
					end else begin
						retry_n = '0;
					end
				end
				pbs_pkg::ST_ERROR: begin
					if (retry_q > cfg.max_retries) begin
						st_a = pbs_pkg::ST_FATAL;
					end else if (elapsed > {16'd0, cfg.error_retry_wait}) begin
						if (retry_q != pbs_pkg::RETRY_SAT) begin
							retry_n = retry_q + 3'd1;
						end
						st_a = pbs_pkg::ST_INIT;
					end
				end
				pbs_pkg::ST_FATAL: begin
					health_n = pbs_pkg::H_FAIL;
					if (elapsed > {16'd0, cfg.fatal_hold_time}) begin
						retry_n = '0;
						st_a    = pbs_pkg::ST_INIT;
					end
				end
				default: ;
			endcase

			in_flow = (st_a == pbs_pkg::ST_SYSCLK) || (st_a == pbs_pkg::ST_WAITLOCK) ||
				(st_a == pbs_pkg::ST_SETUP) || (st_a == pbs_pkg::ST_RUN);
			st_n = st_a;
			if (in_flow) begin
				if (!item.lock_read_ok) begin
					st_n = pbs_pkg::ST_ERROR;
				end else begin
					lock_n = item.lock_read_bit;
				end
			end else begin
				lock_n = 1'b0;
			end
			if (st_n == pbs_pkg::ST_RUN && (!item.irq_poll_ok || !item.status_read_ok)) begin
				st_n = pbs_pkg::ST_ERROR;
			end

			if (st_n != state_q) begin
				changed = 1'b1;
				entry_n = item.now_tick;
				if (state_q != pbs_pkg::ST_RESET) begin
					started = st_n == pbs_pkg::ST_RUN;
					ierr    = st_n == pbs_pkg::ST_ERROR;
				end
			end
		end

		res.fsm_code          = st_n;
		res.device_health     = health_n;
		res.hold_reset_pin    = hold;
		res.release_reset_pin = release_pin;
		res.pulse_reset_pin   = pulse;
		res.lock_status       = lock_n;
		res.state_changed     = changed;
		res.started_event     = started;
		res.iface_error_event = ierr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pbs_pkg::ST_INIT;
			entry_tick_q <= '0;
			retry_q      <= '0;
			health_q     <= pbs_pkg::H_UNKNOWN;
			lock_q       <= 1'b0;
		end else if (step) begin
			state_q      <= st_n;
			entry_tick_q <= entry_n;
			retry_q      <= retry_n;
			health_q     <= health_n;
			lock_q       <= lock_n;
		end
	end
endmodule
`default_nettype wire

FILE: design/pbs_checker.sv
// Port-level checker of the PLL bring-up supervisor, bound to the top level.
// Depends on pbs_pkg and pll_bringup_supervisor_defines.svh.
`default_nettype none
`include "pll_bringup_supervisor_defines.svh"
module pbs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  fsm_code,
	input wire logic [1:0]  device_health,
	input wire logic        hold_reset_pin,
	input wire logic        release_reset_pin,
	input wire logic        pulse_reset_pin,
	input wire logic        lock_status,
	input wire logic        state_changed,
	input wire logic        started_event,
	input wire logic        iface_error_event
);
	// no result may be offered while reset is held
	`PBS_ASSERT_ANY(a_rst_empty, !arst_n |-> !out_valid, "result offered during reset")

	// hold a stalled result unchanged
	`PBS_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(fsm_code) && $stable(state_changed) && $stable(device_health), "stalled result changed")

	// shutdown lands in init, health unknown, lock cleared, no other pin action
	`PBS_ASSERT_CLK(a_shutdown, out_valid && hold_reset_pin |-> fsm_code == pbs_pkg::ST_INIT && state_changed && !lock_status && device_health == pbs_pkg::H_UNKNOWN && !release_reset_pin && !pulse_reset_pin, "bad shutdown result")

	// start event only on a change into run
	`PBS_ASSERT_CLK(a_started, out_valid && started_event |-> fsm_code == pbs_pkg::ST_RUN && state_changed, "start event outside run entry")

	// error event only on a change into error
	`PBS_ASSERT_CLK(a_ierr, out_valid && iface_error_event |-> fsm_code == pbs_pkg::ST_ERROR && state_changed && !started_event, "error event outside error entry")
endmodule

bind pll_bringup_supervisor pbs_checker u_pbs_checker (.*);
`default_nettype wire

FILE: tb/pll_bringup_supervisor_tb.sv
// Self-checking testbench for the PLL bring-up supervisor: drives poll transactions,
// predicts each step's result in a local copy of the state machine and checks the output.
// Depends on pbs_pkg and pll_bringup_supervisor.
module pll_bringup_supervisor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned DRAIN_CYCLES = 8;

	// Register index one past the map; writes there must be dropped.
	localparam logic [2:0] REG_SPARE = pbs_pkg::REG_MAX_RETRIES + 3'd1;

	// Poll result bits for the directed sequence, in item field order.
	localparam logic [9:0] F_GPIO    = 10'h200;
	localparam logic [9:0] F_SRST    = 10'h100;
	localparam logic [9:0] F_DETECT  = 10'h080;
	localparam logic [9:0] F_SYSCLK  = 10'h040;
	localparam logic [9:0] F_CALIB   = 10'h020;
	localparam logic [9:0] F_MAIN    = 10'h010;
	localparam logic [9:0] F_LRD_OK  = 10'h008;
	localparam logic [9:0] F_LRD_BIT = 10'h004;
	localparam logic [9:0] F_IRQ     = 10'h002;
	localparam logic [9:0] F_STATUS  = 10'h001;
	localparam logic [9:0] ALL_OK    = 10'h3FF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	// Input channel; the payload is one struct whose fields feed the ports.
	logic           in_valid = 1'b0;
	logic           in_ready;
	pbs_pkg::item_t poll_bus = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  fsm_code;
	logic [1:0]  device_health;
	logic        hold_reset_pin;
	logic        release_reset_pin;
	logic        pulse_reset_pin;
	logic        lock_status;
	logic        state_changed;
	logic        started_event;
	logic        iface_error_event;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Polls waiting to be driven, and results owed by the block for accepted polls.
	pbs_pkg::item_t polls_to_send[$];
	pbs_pkg::res_t  poll_results_due[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	logic [31:0] tick_cursor = '0;

	// Local copy of the supervisor: configuration and state after the last accepted poll.
	pbs_pkg::cfg_t cfg_shadow = '{
		detect_timeout:   pbs_pkg::DETECT_TO_RST,
		lock_timeout:     pbs_pkg::LOCK_TO_RST,
		error_retry_wait: pbs_pkg::ERR_WAIT_RST,
		fatal_hold_time:  pbs_pkg::FATAL_HOLD_RST,
		max_retries:      pbs_pkg::MAX_RETRIES_RST
	};
	pbs_pkg::st_t sup_state = pbs_pkg::ST_INIT;
	logic [31:0]  sup_entry_tick = '0;
	logic [2:0]   sup_retries = '0;
	pbs_pkg::hl_t sup_health = pbs_pkg::H_UNKNOWN;
	logic         sup_lock = 1'b0;

	pll_bringup_supervisor DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.enable            (poll_bus.enable),
		.now_tick          (poll_bus.now_tick),
		.gpio_test_ok      (poll_bus.gpio_test_ok),
		.soft_reset_ok     (poll_bus.soft_reset_ok),
		.chip_detected     (poll_bus.chip_detected),
		.sysclk_setup_ok   (poll_bus.sysclk_setup_ok),
		.sysclk_calib_ok   (poll_bus.sysclk_calib_ok),
		.main_setup_ok     (poll_bus.main_setup_ok),
		.lock_read_ok      (poll_bus.lock_read_ok),
		.lock_read_bit     (poll_bus.lock_read_bit),
		.irq_poll_ok       (poll_bus.irq_poll_ok),
		.status_read_ok    (poll_bus.status_read_ok),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.fsm_code          (fsm_code),
		.device_health     (device_health),
		.hold_reset_pin    (hold_reset_pin),
		.release_reset_pin (release_reset_pin),
		.pulse_reset_pin   (pulse_reset_pin),
		.lock_status       (lock_status),
		.state_changed     (state_changed),
		.started_event     (started_event),
		.iface_error_event (iface_error_event),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the local supervisor by one poll and return the result it owes.
	function automatic pbs_pkg::res_t step_supervisor(input pbs_pkg::item_t p);
		pbs_pkg::res_t r;
		pbs_pkg::st_t  was;
		pbs_pkg::st_t  goes;
		logic [31:0]   waited;
		r = '0;
		if (!p.enable) begin
			// Shutdown: from any active state drop to init and hold the chip in reset.
			if (sup_state != pbs_pkg::ST_INIT) begin
				sup_state = pbs_pkg::ST_INIT;
				sup_health = pbs_pkg::H_UNKNOWN;
				sup_lock = 1'b0;
				r.hold_reset_pin = 1'b1;
				r.state_changed = 1'b1;
			end
		end else begin
			was = sup_state;
			goes = sup_state;
			waited = p.now_tick - sup_entry_tick;
			case (sup_state)
				pbs_pkg::ST_INIT: begin
					r.release_reset_pin = 1'b1;
					if (p.gpio_test_ok) goes = pbs_pkg::ST_RESET;
					else goes = pbs_pkg::ST_ERROR;
				end
				pbs_pkg::ST_RESET: begin
					r.pulse_reset_pin = 1'b1;
					if (!p.soft_reset_ok) begin
						goes = pbs_pkg::ST_ERROR;
					end else if (p.chip_detected) begin
						sup_health = pbs_pkg::H_NORMAL;
						goes = pbs_pkg::ST_SYSCLK;
					end else begin
						// Missing chip marks the device failed; give up only after the timeout.
						sup_health = pbs_pkg::H_FAIL;
						if (waited > cfg_shadow.detect_timeout) goes = pbs_pkg::ST_ERROR;
					end
				end
				pbs_pkg::ST_SYSCLK: begin
					if (p.sysclk_setup_ok && p.sysclk_calib_ok) goes = pbs_pkg::ST_WAITLOCK;
					else goes = pbs_pkg::ST_ERROR;
				end
				pbs_pkg::ST_WAITLOCK: begin
					// The timeout overrides a lock seen in the same step.
					if (sup_lock) goes = pbs_pkg::ST_SETUP;
					if (waited > cfg_shadow.lock_timeout) goes = pbs_pkg::ST_ERROR;
				end
				pbs_pkg::ST_SETUP: begin
					if (p.main_setup_ok) goes = pbs_pkg::ST_RUN;
					else goes = pbs_pkg::ST_ERROR;
				end
				pbs_pkg::ST_RUN: begin
					if (!sup_lock) goes = pbs_pkg::ST_WAITLOCK;
					else sup_retries = '0;
				end
				pbs_pkg::ST_ERROR: begin
					if (sup_retries > cfg_shadow.max_retries) begin
						goes = pbs_pkg::ST_FATAL;
					end else if (waited > cfg_shadow.error_retry_wait) begin
						if (sup_retries != pbs_pkg::RETRY_SAT) sup_retries = sup_retries + 3'd1;
						goes = pbs_pkg::ST_INIT;
					end
				end
				default: begin
					sup_health = pbs_pkg::H_FAIL;
					if (waited > cfg_shadow.fatal_hold_time) begin
						sup_retries = '0;
						goes = pbs_pkg::ST_INIT;
					end
				end
			endcase

			// States that talk to the chip need a good lock read this step.
			if (goes == pbs_pkg::ST_SYSCLK || goes == pbs_pkg::ST_WAITLOCK ||
					goes == pbs_pkg::ST_SETUP || goes == pbs_pkg::ST_RUN) begin
				if (!p.lock_read_ok) goes = pbs_pkg::ST_ERROR;
				else sup_lock = p.lock_read_bit;
			end else begin
				sup_lock = 1'b0;
			end
			if (goes == pbs_pkg::ST_RUN && (!p.irq_poll_ok || !p.status_read_ok))
				goes = pbs_pkg::ST_ERROR;

			sup_state = goes;
			if (goes != was) begin
				r.state_changed = 1'b1;
				sup_entry_tick = p.now_tick;
				if (was != pbs_pkg::ST_RESET) begin
					r.started_event = (goes == pbs_pkg::ST_RUN);
					r.iface_error_event = (goes == pbs_pkg::ST_ERROR);
				end
			end
		end
		r.fsm_code = sup_state;
		r.device_health = sup_health;
		r.lock_status = sup_lock;
		return r;
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	function automatic logic roll_ok(input int unsigned fail_pct);
		return $urandom_range(99) >= fail_pct;
	endfunction

	function automatic pbs_pkg::item_t make_poll(input logic en, input logic [31:0] t,
			input logic [9:0] f);
		pbs_pkg::item_t p;
		p.enable          = en;
		p.now_tick        = t;
		p.gpio_test_ok    = |(f & F_GPIO);
		p.soft_reset_ok   = |(f & F_SRST);
		p.chip_detected   = |(f & F_DETECT);
		p.sysclk_setup_ok = |(f & F_SYSCLK);
		p.sysclk_calib_ok = |(f & F_CALIB);
		p.main_setup_ok   = |(f & F_MAIN);
		p.lock_read_ok    = |(f & F_LRD_OK);
		p.lock_read_bit   = |(f & F_LRD_BIT);
		p.irq_poll_ok     = |(f & F_IRQ);
		p.status_read_ok  = |(f & F_STATUS);
		return p;
	endfunction

	// Queue a plausible bring-up run: ticks move forward, bus operations mostly pass.
	function automatic void queue_flow(input int unsigned len, input int unsigned step);
		pbs_pkg::item_t p;
		int unsigned    fail_pct;
		logic           chip_gone;
		fail_pct = ($urandom_range(1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 25);
		chip_gone = ($urandom_range(9) == 0);
		repeat (len) begin
			if ($urandom_range(9) == 0) tick_cursor += $urandom_range(0, 4 * step);
			else tick_cursor += $urandom_range(0, step);
			p.enable          = $urandom_range(99) >= 2;
			p.now_tick        = tick_cursor;
			p.gpio_test_ok    = roll_ok(fail_pct);
			p.soft_reset_ok   = roll_ok(fail_pct);
			p.chip_detected   = chip_gone ? 1'b0 : roll_ok(fail_pct);
			p.sysclk_setup_ok = roll_ok(fail_pct);
			p.sysclk_calib_ok = roll_ok(fail_pct);
			p.main_setup_ok   = roll_ok(fail_pct);
			p.lock_read_ok    = roll_ok(fail_pct);
			p.lock_read_bit   = $urandom_range(99) < 85;
			p.irq_poll_ok     = roll_ok(fail_pct);
			p.status_read_ok  = roll_ok(fail_pct);
			polls_to_send.push_back(p);
		end
	endfunction

	// Queue a poll with every bit random, the tick included.
	function automatic void queue_noise();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		polls_to_send.push_back(raw[$bits(pbs_pkg::item_t)-1:0]);
	endfunction

	// Sender: present the next queued poll, or idle, once the current one is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) poll_results_due.push_back(step_supervisor(poll_bus));
			if (!in_valid || in_ready) begin
				if (polls_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					poll_bus <= polls_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result transaction against the oldest owed result.
	always @(posedge clk) begin
		pbs_pkg::res_t want;
		pbs_pkg::res_t got;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got.fsm_code          = pbs_pkg::st_t'(fsm_code);
				got.device_health     = pbs_pkg::hl_t'(device_health);
				got.hold_reset_pin    = hold_reset_pin;
				got.release_reset_pin = release_reset_pin;
				got.pulse_reset_pin   = pulse_reset_pin;
				got.lock_status       = lock_status;
				got.state_changed     = state_changed;
				got.started_event     = started_event;
				got.iface_error_event = iface_error_event;
				if (poll_results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, got);
					fail_count++;
				end else begin
					want = poll_results_due.pop_front();
					compare_field("fsm_code", want.fsm_code, got.fsm_code);
					compare_field("device_health", want.device_health, got.device_health);
					compare_field("hold_reset_pin", want.hold_reset_pin, got.hold_reset_pin);
					compare_field("release_reset_pin", want.release_reset_pin,
						got.release_reset_pin);
					compare_field("pulse_reset_pin", want.pulse_reset_pin, got.pulse_reset_pin);
					compare_field("lock_status", want.lock_status, got.lock_status);
					compare_field("state_changed", want.state_changed, got.state_changed);
					compare_field("started_event", want.started_event, got.started_event);
					compare_field("iface_error_event", want.iface_error_event,
						got.iface_error_event);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("pll_bringup_supervisor_tb: FAIL");
		$finish;
	end

	// One register transaction: setup phase, then access phase until pready.
	task automatic reg_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] shadow_reg(input logic [2:0] idx);
		case (idx)
			pbs_pkg::REG_DETECT_TO:   return {16'd0, cfg_shadow.detect_timeout};
			pbs_pkg::REG_LOCK_TO:     return {16'd0, cfg_shadow.lock_timeout};
			pbs_pkg::REG_ERR_WAIT:    return {16'd0, cfg_shadow.error_retry_wait};
			pbs_pkg::REG_FATAL_HOLD:  return {16'd0, cfg_shadow.fatal_hold_time};
			pbs_pkg::REG_MAX_RETRIES: return {29'd0, cfg_shadow.max_retries};
			default:                  return '0;
		endcase
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] unused;
		reg_access(1'b1, idx, val, unused);
		case (idx)
			pbs_pkg::REG_DETECT_TO:   cfg_shadow.detect_timeout = val[15:0];
			pbs_pkg::REG_LOCK_TO:     cfg_shadow.lock_timeout = val[15:0];
			pbs_pkg::REG_ERR_WAIT:    cfg_shadow.error_retry_wait = val[15:0];
			pbs_pkg::REG_FATAL_HOLD:  cfg_shadow.fatal_hold_time = val[15:0];
			pbs_pkg::REG_MAX_RETRIES: cfg_shadow.max_retries = val[2:0];
			default: ;
		endcase
	endtask

	task automatic reg_check(input logic [2:0] idx);
		logic [31:0] got;
		reg_access(1'b0, idx, '0, got);
		if (got !== shadow_reg(idx)) begin
			$display("%0t: register %0d readback, expected %h, got %h", $time, idx,
				shadow_reg(idx), got);
			fail_count++;
		end
	endtask

	// Load a full setting, poke the unmapped slot, then read every register back.
	task automatic load_config(input logic [15:0] detect_to, input logic [15:0] lock_to,
			input logic [15:0] err_wait, input logic [15:0] fatal_hold,
			input logic [2:0] retries);
		reg_write(pbs_pkg::REG_DETECT_TO, {16'($urandom_range(65535)), detect_to});
		reg_write(pbs_pkg::REG_LOCK_TO, {16'd0, lock_to});
		reg_write(pbs_pkg::REG_ERR_WAIT, {16'd0, err_wait});
		reg_write(pbs_pkg::REG_FATAL_HOLD, {16'd0, fatal_hold});
		reg_write(pbs_pkg::REG_MAX_RETRIES, {29'd0, retries});
		reg_write(REG_SPARE, $urandom);
		for (int i = 0; i <= pbs_pkg::REG_MAX_RETRIES; i++) reg_check(i[2:0]);
	endtask

	// Hold until nothing is queued, on the wire, or owed; sample away from the edge.
	task automatic wait_drained();
		do @(negedge clk);
		while (polls_to_send.size() != 0 || in_valid || poll_results_due.size() != 0);
	endtask

	// Set the idle mix, queue the random polls of one phase, and let them run out.
	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count, input int unsigned step);
		int unsigned added;
		int unsigned len;
		@(negedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		added = 0;
		while (added < count) begin
			if ($urandom_range(99) < 80) begin
				len = $urandom_range(8, 30);
				queue_flow(len, step);
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) queue_noise();
			end
			added += len;
		end
		wait_drained();
	endtask

	initial begin
		logic [15:0] lim;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults must read back before anything is written.
		for (int i = 0; i <= pbs_pkg::REG_MAX_RETRIES; i++) reg_check(i[2:0]);

		// Directed walk at the reset defaults: disabled idle, missing chip up to and past
		// the detect timeout, a clean bring-up into run, lock loss, lock racing its
		// timeout, shutdown from error, pin test failure and soft reset failure.
		@(negedge clk);
		polls_to_send.push_back(make_poll(1'b0, 32'hFFFF_FFFF, ALL_OK));
		polls_to_send.push_back(make_poll(1'b0, 32'd0, '0));
		polls_to_send.push_back(make_poll(1'b1, 32'd10, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd20, ALL_OK & ~F_DETECT));
		polls_to_send.push_back(make_poll(1'b1, 32'd2010, ALL_OK & ~F_DETECT));
		polls_to_send.push_back(make_poll(1'b1, 32'd2011, ALL_OK & ~F_DETECT));
		polls_to_send.push_back(make_poll(1'b1, 32'd3011, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd3012, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd3013, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd3014, ALL_OK & ~F_LRD_BIT));
		polls_to_send.push_back(make_poll(1'b1, 32'd3015, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd3016, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd3017, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd3018, ALL_OK & ~F_LRD_BIT));
		polls_to_send.push_back(make_poll(1'b1, 32'd3019, ALL_OK & ~F_LRD_BIT));
		polls_to_send.push_back(make_poll(1'b1, 32'd3020, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd5020, ALL_OK));
		polls_to_send.push_back(make_poll(1'b0, 32'd5021, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd5022, ALL_OK & ~F_GPIO));
		polls_to_send.push_back(make_poll(1'b1, 32'd6023, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd6024, ALL_OK));
		polls_to_send.push_back(make_poll(1'b1, 32'd6025, ALL_OK & ~F_SRST));
		polls_to_send.push_back(make_poll(1'b1, 32'd6026, ALL_OK & ~F_IRQ));
		tick_cursor = 32'd7000;
		run_phase(0, 0, 115, 700);

		// All limits zero: any tick advance times out, first retry goes fatal.
		load_config(16'd0, 16'd0, 16'd0, 16'd0, 3'd0);
		tick_cursor = $urandom;
		run_phase(73, 0, 115, 2);

		// All limits at the top, retries saturate; ticks start just below the wrap.
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
		tick_cursor = 32'hFFFF_0000;
		run_phase(0, 73, 115, 30000);

		// Short limits with unlimited retries, to spin through many retry rounds.
		lim = 16'($urandom_range(1, 16));
		load_config(lim, 16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
			16'($urandom_range(1, 16)), 3'd7);
		tick_cursor = $urandom;
		run_phase(7, 7, 115, 8);

		load_config(16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
			16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)), 3'd1);
		tick_cursor = $urandom;
		run_phase(0, 0, 115, 8);

		load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			3'($urandom_range(7)));
		tick_cursor = $urandom;
		run_phase(7, 7, 115, 20000);

		// Let any stray result surface before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("pll_bringup_supervisor_tb: PASS");
		end else begin
			$display("pll_bringup_supervisor_tb: FAIL");
		end
		$finish;
	end

endmodule
